[rtl/core/ilic_pkg.sv]
// ----------------------------------------------------------------------------
// ilic_pkg: shared definitions for the interval list intersection core
// Sizes, request codes, state encoding and the structs passed between modules.
// ----------------------------------------------------------------------------
package ilic_pkg;

	// Number of ranges each list can hold.
	localparam int LIST_DEPTH = 16;
	// Width of a stored mark.
	localparam int MARK_BITS = 32;

	// Width of a port field and of the gap tolerance register.
	localparam int FIELD_BITS = 32;
	// Width used to compare a gap against the tolerance.
	localparam int GAP_BITS = (MARK_BITS > FIELD_BITS) ? MARK_BITS : FIELD_BITS;
	// Address bits of a list memory.
	localparam int IDX_BITS = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	// Bits of a fill count or walk pointer; it must hold LIST_DEPTH itself.
	localparam int CNT_BITS = $clog2(LIST_DEPTH + 1);
	// One stored entry holds the end mark above the begin mark.
	localparam int ENTRY_BITS = 2 * MARK_BITS;

	// Configuration register indexes.
	localparam int REG_SEEK_GAP_TOL = 0;

	typedef logic [MARK_BITS-1:0]  mark_t;
	typedef logic [ENTRY_BITS-1:0] entry_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [FIELD_BITS-1:0] field_t;
	typedef logic [GAP_BITS-1:0]   gap_t;

	// Request codes; the fourth code is unused and ignored.
	localparam logic [1:0] REQ_LOAD_A = 2'd0;
	localparam logic [1:0] REQ_LOAD_B = 2'd1;
	localparam logic [1:0] REQ_RUN    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	// Access to one list memory: one write and one read address per cycle.
	typedef struct packed {
		logic   we;
		idx_t   waddr;
		entry_t wdata;
		idx_t   raddr;
	} ram_req_t;

	// One result item.
	typedef struct packed {
		field_t rbegin;
		field_t rend;
		logic   is_empty;
		logic   last;
		logic   dropped;
	} result_t;

endpackage

[rtl/core/interval_list_intersect_coalesce_core.sv]
// ----------------------------------------------------------------------------
// interval_list_intersect_coalesce_core: sorted range list intersection
// Loads two lists of half-open ranges and emits their ordered intersection,
// optionally joining results separated by a small gap.
// ----------------------------------------------------------------------------
// A load item (req_type 0 for list A, 1 for list B) is taken while busy is low
// and busy never rises for it; each list holds LIST_DEPTH ranges and further
// loads are dropped and reported through load_dropped on the next run. A run
// item (req_type 2) raises busy for the whole walk, which takes at most
// count_a + count_b - 1 merge steps, each advancing one list pointer. The
// walk performs one step per cycle: both list memories are read every cycle at
// the pointers chosen by the previous step, and the comparison of the two ends
// sets the next pointers. Result items appear on out_begin, out_end and the
// flags for exactly one cycle each, marked by out_valid; there is no way to
// stall them, so the receiver must take every item as it comes. An item is
// held until the following overlap proves it cannot be extended, so it leaves
// after the overlap that opened it, never with it, and the last item of a
// run (out_last) is presented in the first cycle with busy low, at the same
// clock edge at which busy falls. A run over an empty
// intersection gives a single item with out_is_empty set and zero marks. Both
// lists and the drop flag are cleared when a run ends. The gap tolerance is
// written through the APB-style port (every address selects it) and must only
// change while the block is idle.
module interval_list_intersect_coalesce_core (
	input  logic        clk,
	input  logic        arst_n,
	// Command channel.
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [31:0] range_begin,
	input  logic [31:0] range_end,
	// Result channel.
	output logic        out_valid,
	output logic [31:0] out_begin,
	output logic [31:0] out_end,
	output logic        out_is_empty,
	output logic        out_last,
	output logic        load_dropped,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ilic_pkg::field_t   gap_tol;
	ilic_pkg::ram_req_t ram_a, ram_b;
	ilic_pkg::entry_t   rdata_a, rdata_b;
	ilic_pkg::result_t  res;

	// The tolerance register sits behind the configuration port.
	ilic_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gap_tol (gap_tol)
	);

	// List A storage: ranges are packed with the end mark in the upper half.
	ilic_ram #(
		.WIDTH (ilic_pkg::ENTRY_BITS),
		.DEPTH (ilic_pkg::LIST_DEPTH)
	) u_ram_a (
		.clk   (clk),
		.we    (ram_a.we),
		.waddr (ram_a.waddr),
		.wdata (ram_a.wdata),
		.raddr (ram_a.raddr),
		.rdata (rdata_a)
	);

	// List B storage, same layout.
	ilic_ram #(
		.WIDTH (ilic_pkg::ENTRY_BITS),
		.DEPTH (ilic_pkg::LIST_DEPTH)
	) u_ram_b (
		.clk   (clk),
		.we    (ram_b.we),
		.waddr (ram_b.waddr),
		.wdata (ram_b.wdata),
		.raddr (ram_b.raddr),
		.rdata (rdata_b)
	);

	// The sequencer owns the fill counts, walk pointers and the pending result.
	ilic_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req_type    (req_type),
		.range_begin (range_begin),
		.range_end   (range_end),
		.gap_tol     (gap_tol),
		.busy        (busy),
		.ram_a       (ram_a),
		.ram_b       (ram_b),
		.rdata_a     (rdata_a),
		.rdata_b     (rdata_b),
		.res_valid   (out_valid),
		.res         (res)
	);

	assign out_begin    = res.rbegin;
	assign out_end      = res.rend;
	assign out_is_empty = res.is_empty;
	assign out_last     = res.last;
	assign load_dropped = res.dropped;

endmodule

[rtl/core/ilic_ram.sv]
// ----------------------------------------------------------------------------
// ilic_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ilic_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/ilic_cfg.sv]
// ----------------------------------------------------------------------------
// ilic_cfg: configuration register file
// Holds the gap tolerance behind a single-register APB-style port.
// ----------------------------------------------------------------------------
module ilic_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output ilic_pkg::field_t    gap_tol
);

	logic                 wr_en;
	ilic_pkg::field_t     gap_tol_q;

	// Only one register exists, so every byte address selects it.
	assign wr_en  = psel && penable && pwrite && pready && (paddr == paddr);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_tol_q <= '0;
		end else if (wr_en) begin
			gap_tol_q <= ilic_pkg::field_t'(pwdata);
		end
	end

	assign prdata  = 32'(gap_tol_q);
	assign gap_tol = gap_tol_q;

endmodule

[rtl/core/ilic_ctrl.sv]
// ----------------------------------------------------------------------------
// ilic_ctrl: load and merge sequencer
// Appends ranges to the list memories and walks both lists on a run.
// ----------------------------------------------------------------------------
module ilic_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           req_type,
	input  logic [31:0]          range_begin,
	input  logic [31:0]          range_end,
	input  ilic_pkg::field_t     gap_tol,
	output logic                 busy,
	output ilic_pkg::ram_req_t   ram_a,
	output ilic_pkg::ram_req_t   ram_b,
	input  ilic_pkg::entry_t     rdata_a,
	input  ilic_pkg::entry_t     rdata_b,
	output logic                 res_valid,
	output ilic_pkg::result_t    res
);

	ilic_pkg::state_t  state_q, state_d;
	ilic_pkg::cnt_t    cnt_a_q, cnt_b_q, ia_q, ib_q, ia_d, ib_d;
	logic              dropped_q;
	logic              have_pend_q;
	ilic_pkg::mark_t   pend_lo_q, pend_hi_q;
	logic              res_valid_q;
	ilic_pkg::result_t res_q;

	logic              accept, walking, more, step_a;
	logic              load_a, load_b, full_a, full_b, run_req;
	ilic_pkg::mark_t   a_lo, a_hi, b_lo, b_hi, ov_lo, ov_hi, gap;
	logic              ov_nonempty, coalesce;
	ilic_pkg::entry_t  load_entry;

	assign busy    = (state_q != ilic_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign walking = (state_q == ilic_pkg::ST_WALK);

	assign full_a  = (cnt_a_q >= ilic_pkg::cnt_t'(ilic_pkg::LIST_DEPTH));
	assign full_b  = (cnt_b_q >= ilic_pkg::cnt_t'(ilic_pkg::LIST_DEPTH));
	assign load_a  = accept && (req_type == ilic_pkg::REQ_LOAD_A);
	assign load_b  = accept && (req_type == ilic_pkg::REQ_LOAD_B);
	assign run_req = accept && (req_type == ilic_pkg::REQ_RUN);

	assign load_entry = {ilic_pkg::mark_t'(range_end), ilic_pkg::mark_t'(range_begin)};

	// Current entries of both lists, read in the previous cycle.
	assign a_lo = rdata_a[ilic_pkg::MARK_BITS-1:0];
	assign a_hi = rdata_a[ilic_pkg::ENTRY_BITS-1:ilic_pkg::MARK_BITS];
	assign b_lo = rdata_b[ilic_pkg::MARK_BITS-1:0];
	assign b_hi = rdata_b[ilic_pkg::ENTRY_BITS-1:ilic_pkg::MARK_BITS];

	assign ov_lo       = (a_lo > b_lo) ? a_lo : b_lo;
	assign ov_hi       = (a_hi < b_hi) ? a_hi : b_hi;
	assign ov_nonempty = (ov_lo < ov_hi);
	assign gap         = ov_lo - pend_hi_q;
	// A gap is only measured forward; an overlap behind the pending end starts anew.
	assign coalesce    = (gap_tol != '0) && have_pend_q && (ov_lo >= pend_hi_q) &&
		(ilic_pkg::gap_t'(gap) <= ilic_pkg::gap_t'(gap_tol));

	assign more   = (ia_q < cnt_a_q) && (ib_q < cnt_b_q);
	assign step_a = (a_hi < b_hi);

	// Next pointers also address the memories, so a step completes every cycle.
	always_comb begin
		ia_d    = ia_q;
		ib_d    = ib_q;
		state_d = state_q;
		unique case (state_q)
			ilic_pkg::ST_IDLE: begin
				if (run_req) begin
					state_d = ilic_pkg::ST_WALK;
				end
			end
			ilic_pkg::ST_WALK: begin
				if (more) begin
					if (step_a) begin
						ia_d = ia_q + 1'b1;
					end else begin
						ib_d = ib_q + 1'b1;
					end
				end else begin
					ia_d    = '0;
					ib_d    = '0;
					state_d = ilic_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ilic_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ilic_pkg::ST_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			ia_q        <= '0;
			ib_q        <= '0;
			dropped_q   <= 1'b0;
			have_pend_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ia_q        <= ia_d;
			ib_q        <= ib_d;
			res_valid_q <= 1'b0;
			if (load_a) begin
				if (full_a) begin
					dropped_q <= 1'b1;
				end else begin
					cnt_a_q <= cnt_a_q + 1'b1;
				end
			end
			if (load_b) begin
				if (full_b) begin
					dropped_q <= 1'b1;
				end else begin
					cnt_b_q <= cnt_b_q + 1'b1;
				end
			end
			if (walking) begin
				if (more) begin
					if (ov_nonempty && !coalesce) begin
						res_valid_q <= have_pend_q;
						have_pend_q <= 1'b1;
					end
				end else begin
					res_valid_q <= 1'b1;
					have_pend_q <= 1'b0;
					cnt_a_q     <= '0;
					cnt_b_q     <= '0;
					dropped_q   <= 1'b0;
				end
			end
		end
	end

	// Pending range and result payload.
	always_ff @(posedge clk) begin
		if (walking) begin
			if (more) begin
				if (ov_nonempty) begin
					if (coalesce) begin
						pend_hi_q <= ov_hi;
					end else begin
						pend_lo_q <= ov_lo;
						pend_hi_q <= ov_hi;
						res_q.rbegin   <= ilic_pkg::field_t'(pend_lo_q);
						res_q.rend     <= ilic_pkg::field_t'(pend_hi_q);
						res_q.is_empty <= 1'b0;
						res_q.last     <= 1'b0;
						res_q.dropped  <= dropped_q;
					end
				end
			end else begin
				res_q.rbegin   <= have_pend_q ? ilic_pkg::field_t'(pend_lo_q) : '0;
				res_q.rend     <= have_pend_q ? ilic_pkg::field_t'(pend_hi_q) : '0;
				res_q.is_empty <= !have_pend_q;
				res_q.last     <= 1'b1;
				res_q.dropped  <= dropped_q;
			end
		end
	end

	always_comb begin
		ram_a.we    = load_a && !full_a;
		ram_a.waddr = cnt_a_q[ilic_pkg::IDX_BITS-1:0];
		ram_a.wdata = load_entry;
		ram_a.raddr = ia_d[ilic_pkg::IDX_BITS-1:0];
		ram_b.we    = load_b && !full_b;
		ram_b.waddr = cnt_b_q[ilic_pkg::IDX_BITS-1:0];
		ram_b.wdata = load_entry;
		ram_b.raddr = ib_d[ilic_pkg::IDX_BITS-1:0];
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/core/ilic_chk.sv]
// ----------------------------------------------------------------------------
// ilic_chk: port-level checks for the intersection core
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module ilic_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  req_type,
	input logic        out_valid,
	input logic [31:0] out_begin,
	input logic [31:0] out_end,
	input logic        out_is_empty,
	input logic        out_last
);

	// A run item always raises busy.
	a_run_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == ilic_pkg::REQ_RUN)) |=> busy)
		else $error("run item did not raise busy");

	// Every item but the last leaves while the walk is still going.
	a_mid_item_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_last) |-> busy)
		else $error("non-final item after the walk ended");

	// The last item of a run is never directly followed by another.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_last) |=> !out_valid)
		else $error("item right after the final item");

	// An empty intersection is reported alone, with zero marks.
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_is_empty) |->
		(out_last && (out_begin == 32'd0) && (out_end == 32'd0)))
		else $error("malformed empty item");

endmodule

bind interval_list_intersect_coalesce_core ilic_chk u_ilic_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.req_type     (req_type),
	.out_valid    (out_valid),
	.out_begin    (out_begin),
	.out_end      (out_end),
	.out_is_empty (out_is_empty),
	.out_last     (out_last)
);
